>>> rtl/mdq_pkg.sv
// ----------------------------------------------------------------------------
// mdq_pkg: shared definitions for the message deque
// Command codes, field widths and the default pool depth.
// ----------------------------------------------------------------------------
package mdq_pkg;

    localparam int unsigned DEPTH_DEFAULT = 16;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CMD_W   = 2;
    localparam int unsigned FILL_W  = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_TOP    = 2'd0,
        CMD_PUSH_BOTTOM = 2'd1,
        CMD_POP_TOP     = 2'd2,
        CMD_CLEAR       = 2'd3
    } t_cmd;

endpackage

>>> rtl/mdq_ram.sv
// ----------------------------------------------------------------------------
// mdq_ram: generic simple dual-port RAM
// One write port and one read port; read data registered, held when idle.
// ----------------------------------------------------------------------------
module mdq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/message_deque_drop_oldest.sv
// ----------------------------------------------------------------------------
// message_deque_drop_oldest: bounded byte deque that overwrites when full
//
// Input stream (s_axis): one command beat per step - push top, push bottom,
// pop top or clear - with the byte that pushes store. Output stream (m_axis):
// exactly one result beat per command, carrying the popped byte (or the
// configured empty code), the empty flag in tuser and the fill count after
// the step. Entries live in a circular buffer in one RAM, addressed by a
// bottom pointer and a count; a full push-top drops the oldest entry, a full
// push-bottom loses the top one.
// The result is valid in the cycle after the command beat. One command per
// cycle unless the receiver stalls; the single RAM read port serves a pop in
// the cycle the beat is taken, its registered data the output byte next cycle.
// Reset empties the pool and sets the empty code to zero; no clearing pass is
// run since entries above the count are never read. When the receiver stalls,
// the result beat holds and the input stays ready only as the result drains.
// The empty code register is written through i_cfg_we / i_cfg_wdata.
// ----------------------------------------------------------------------------
module message_deque_drop_oldest #(
    parameter int unsigned DEPTH = mdq_pkg::DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,     // empty_code

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,    // [1:0] command, [9:2] push_byte, rest zero

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,    // [7:0] popped_byte, [12:8] fill_count, rest zero
    output logic        m_axis_tuser     // [0] was_empty
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned BW = mdq_pkg::BYTE_W;
    localparam int unsigned FW = mdq_pkg::FILL_W;

    // Control state
    logic [AW-1:0] r_bot, n_bot;
    logic [CW-1:0] r_count, n_count;
    logic          r_out_valid;
    logic          r_out_from_ram;
    logic [BW-1:0] r_empty_code;

    // Result payload
    logic [BW-1:0] r_out_byte;
    logic          r_out_empty;
    logic [CW-1:0] r_out_count;

    // Decoded input beat
    mdq_pkg::t_cmd s_cmd;
    logic [BW-1:0] s_byte;
    logic          s_accept;
    logic          s_full;
    logic          s_empty;

    // Address arithmetic, modulo DEPTH
    logic [AW:0]   s_top_sum;
    logic [AW-1:0] s_top_free;
    logic [AW:0]   s_pop_sum;
    logic [AW-1:0] s_pop_addr;
    logic [AW-1:0] s_bot_inc;
    logic [AW-1:0] s_bot_dec;

    // RAM ports
    logic          s_we;
    logic [AW-1:0] s_waddr;
    logic          s_re;
    logic [BW-1:0] s_rdata;

    logic          n_out_empty;
    logic [CW+FW-1:0] s_count_ext;

    assign s_cmd    = mdq_pkg::t_cmd'(s_axis_tdata[1:0]);
    assign s_byte   = s_axis_tdata[9:2];
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign s_full   = (r_count == CW'(DEPTH));
    assign s_empty  = (r_count == '0);

    // First free slot above the top: bot + count, with count below DEPTH
    assign s_top_sum  = {1'b0, r_bot} + (AW+1)'(r_count);
    assign s_top_free = (s_top_sum >= (AW+1)'(DEPTH)) ?
                        AW'(s_top_sum - (AW+1)'(DEPTH)) : s_top_sum[AW-1:0];

    // Top entry: bot + count - 1, only used when count is nonzero
    assign s_pop_sum  = s_top_sum - (AW+1)'(1);
    assign s_pop_addr = (s_pop_sum >= (AW+1)'(DEPTH)) ?
                        AW'(s_pop_sum - (AW+1)'(DEPTH)) : s_pop_sum[AW-1:0];

    assign s_bot_inc = (r_bot == AW'(DEPTH - 1)) ? '0 : r_bot + AW'(1);
    assign s_bot_dec = (r_bot == '0) ? AW'(DEPTH - 1) : r_bot - AW'(1);

    always_comb begin
        n_bot       = r_bot;
        n_count     = r_count;
        s_we        = 1'b0;
        s_waddr     = s_top_free;
        s_re        = 1'b0;
        n_out_empty = 1'b0;
        case (s_cmd)
            mdq_pkg::CMD_PUSH_TOP: begin
                s_we = s_accept;
                if (s_full) begin
                    // overwrite the oldest slot, which becomes the new top
                    s_waddr = r_bot;
                    n_bot   = s_bot_inc;
                end else begin
                    s_waddr = s_top_free;
                    n_count = r_count + CW'(1);
                end
            end
            mdq_pkg::CMD_PUSH_BOTTOM: begin
                // when full, the slot below bottom holds the top: drop it
                s_we    = s_accept;
                s_waddr = s_bot_dec;
                n_bot   = s_bot_dec;
                if (!s_full) begin
                    n_count = r_count + CW'(1);
                end
            end
            mdq_pkg::CMD_POP_TOP: begin
                if (s_empty) begin
                    n_out_empty = 1'b1;
                end else begin
                    s_re    = s_accept;
                    n_count = r_count - CW'(1);
                end
            end
            default: begin
                n_count = '0;
            end
        endcase
    end

    mdq_ram #(
        .WIDTH (BW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_byte),
        .i_re    (s_re),
        .i_raddr (s_pop_addr),
        .o_rdata (s_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bot          <= '0;
            r_count        <= '0;
            r_out_valid    <= 1'b0;
            r_out_from_ram <= 1'b0;
            r_empty_code   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_empty_code <= i_cfg_wdata;
            end
            if (s_accept) begin
                r_bot          <= n_bot;
                r_count        <= n_count;
                r_out_valid    <= 1'b1;
                r_out_from_ram <= s_re;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the result payload until the next beat is taken
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_out_byte  <= r_empty_code;
            r_out_empty <= n_out_empty;
            r_out_count <= n_count;
        end
    end

    assign s_count_ext = {{FW{1'b0}}, r_out_count};

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, s_count_ext[FW-1:0],
                            r_out_from_ram ? s_rdata : r_out_byte};
    assign m_axis_tuser  = r_out_empty;

endmodule
